FILE: rtl/core/eqc_pkg.sv
// shared types, constants and the arctangent table of the equirect-to-cubemap sampler
// no dependencies; eqc_cordic, eqc_front, eqc_back and the top level import this package
`default_nettype none

package eqc_pkg;

  // source store
  localparam int SRC_PIXELS = 32768;
  localparam int SRC_AW     = 15;
  localparam int RGB_W      = 24;

  // configuration register widths
  localparam int FSZ_W = 11;
  localparam int SW_W  = 9;
  localparam int SH_W  = 8;
  localparam int REG_W = 2;

  localparam logic [REG_W-1:0] REG_FACE_SIZE  = 2'd0;
  localparam logic [REG_W-1:0] REG_SRC_WIDTH  = 2'd1;
  localparam logic [REG_W-1:0] REG_SRC_HEIGHT = 2'd2;

  localparam logic [FSZ_W-1:0] FACE_SIZE_RST  = 11'd256;
  localparam logic [SW_W-1:0]  SRC_WIDTH_RST  = 9'd256;
  localparam logic [SH_W-1:0]  SRC_HEIGHT_RST = 8'd128;

  // arithmetic
  localparam int ONE_Q14      = 16384;
  localparam int ANG_PI       = 1048576;
  localparam int ANG_HALF_PI  = 524288;
  localparam int KINV_Q15     = 19899;
  localparam int DIV_STEPS    = 15;
  localparam int CORDIC_DW    = 27;
  localparam int ANGW         = 24;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // atan(2^-k) in units of pi / 2^20
  localparam logic [ANGW-1:0] ATAN_TAB [ATAN_LEN] = '{
    24'd262144, 24'd154753, 24'd81767, 24'd41506, 24'd20834, 24'd10427, 24'd5215, 24'd2608,
    24'd1304,   24'd652,    24'd326,   24'd163,   24'd81,    24'd41,    24'd20,   24'd10,
    24'd5,      24'd3,      24'd1,     24'd1,     24'd0,     24'd0,     24'd0,    24'd0
  };

  typedef enum logic [2:0] {
    FACE_BACK,
    FACE_LEFT,
    FACE_FRONT,
    FACE_RIGHT,
    FACE_TOP,
    FACE_BOTTOM,
    FACE_DIAG
  } face_e;

  // effective configuration, zero values already replaced by one
  typedef struct packed {
    logic [FSZ_W-1:0] fsz;
    logic [SW_W-1:0]  w;
    logic [SH_W-1:0]  h;
  } eqc_cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic              proj;
    face_e             face;
    logic              sat_a;
    logic              sat_b;
    logic [9:0]        px;
    logic [9:0]        py;
    logic [SRC_AW-1:0] addr;
    logic [RGB_W-1:0]  rgb;
  } eqc_item_t;

  // control carried along the back pipeline
  typedef struct packed {
    logic              vld;
    logic              proj;
    logic [SRC_AW-1:0] addr;
    logic [RGB_W-1:0]  rgb;
  } tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/eqc_fifo.sv
// small synchronous queue used between front and back and on the result side
// depends on nothing; DEPTH must be a power of two
`default_nettype none

module eqc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

FILE: rtl/core/eqc_ram.sv
// generic ram: one write port, two read ports with registered read data
// depends on nothing
`default_nettype none

module eqc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/eqc_cordic.sv
// pipelined vectoring cordic: angle of (x, y) in units of pi/2^20 and raw magnitude
// depends on eqc_pkg for the arctangent table and angle constants
`default_nettype none

module eqc_cordic #(
  parameter int STEPS = 16,
  parameter int DW    = 27,
  parameter int AW    = 24,
  parameter int PAY_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  logic [PAY_W-1:0]     pay_i,
  output logic                 vld_o,
  output logic signed [AW-1:0] ang_o,
  output logic signed [DW-1:0] mag_o,
  output logic [PAY_W-1:0]     pay_o
);

  import eqc_pkg::*;

  localparam logic signed [AW-1:0] PI_S = AW'(ANG_PI);

  typedef struct packed {
    logic             vld;
    logic             zero;
    logic [DW-1:0]    x;
    logic [DW-1:0]    y;
    logic [AW-1:0]    ang;
    logic [PAY_W-1:0] pay;
  } cst_t;

  cst_t st_q [STEPS+1];
  cst_t pre_d;

  // negative x: rotate by pi first
  always_comb begin
    pre_d      = '0;
    pre_d.vld  = vld_i;
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.pay  = pay_i;
    if (x_i < 0) begin
      pre_d.x   = -x_i;
      pre_d.y   = -y_i;
      pre_d.ang = (y_i >= 0) ? PI_S : -PI_S;
    end else begin
      pre_d.x   = x_i;
      pre_d.y   = y_i;
      pre_d.ang = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
    end else if (en_i) begin
      st_q[0] <= pre_d;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [AW-1:0] ATAN_K = AW'(ATAN_TAB[k]);
    cst_t                 d;
    logic signed [DW-1:0] dx, dy;

    always_comb begin
      dx = $signed(st_q[k].y) >>> k;
      dy = $signed(st_q[k].x) >>> k;
      d  = st_q[k];
      if (!st_q[k].y[DW-1]) begin
        d.x   = st_q[k].x + dx;
        d.y   = st_q[k].y - dy;
        d.ang = st_q[k].ang + ATAN_K;
      end else begin
        d.x   = st_q[k].x - dx;
        d.y   = st_q[k].y + dy;
        d.ang = st_q[k].ang - ATAN_K;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k+1] <= '0;
      end else if (en_i) begin
        st_q[k+1] <= d;
      end
    end
  end

  // zero vector gives angle and magnitude zero
  assign vld_o = st_q[STEPS].vld;
  assign ang_o = st_q[STEPS].zero ? '0 : $signed(st_q[STEPS].ang);
  assign mag_o = st_q[STEPS].zero ? '0 : $signed(st_q[STEPS].x);
  assign pay_o = st_q[STEPS].pay;

endmodule

`default_nettype wire

FILE: rtl/core/eqc_front.sv
// front stage: takes items off the input port, decodes face and edge saturation
// depends on eqc_pkg; feeds the queue in front of eqc_back
`default_nettype none

module eqc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  eqc_pkg::eqc_cfg_t   cfg_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic                req_type_i,
  input  logic [2:0]          face_i,
  input  logic [9:0]          pixel_x_i,
  input  logic [9:0]          pixel_y_i,
  input  logic [14:0]         src_addr_i,
  input  logic [23:0]         src_rgb_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output eqc_pkg::eqc_item_t  q_item_o
);

  import eqc_pkg::*;

  logic      valid_q;
  eqc_item_t item_q, item_d;
  logic      accept;

  assign full_o   = valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q && !q_full_i;
  assign q_item_o = item_q;

  always_comb begin
    item_d.proj  = req_type_i;
    item_d.face  = (face_i < 3'd6) ? face_e'(face_i) : FACE_DIAG;
    // pixel at or past the face edge saturates to 2.0
    item_d.sat_a = ({1'b0, pixel_x_i} >= cfg_i.fsz);
    item_d.sat_b = ({1'b0, pixel_y_i} >= cfg_i.fsz);
    item_d.px    = pixel_x_i;
    item_d.py    = pixel_y_i;
    item_d.addr  = src_addr_i;
    item_d.rgb   = src_rgb_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (q_push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/eqc_back.sv
// back pipeline: divider, direction, two cordics, source coordinates, fetch, blend
// depends on eqc_pkg, eqc_cordic and eqc_ram
`default_nettype none

module eqc_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eqc_pkg::eqc_cfg_t  cfg_i,
  input  logic               q_empty_i,
  input  eqc_pkg::eqc_item_t q_item_i,
  output logic               q_pop_o,
  input  logic               out_full_i,
  output logic               out_push_o,
  output logic [23:0]        out_rgb_o
);

  import eqc_pkg::*;

  localparam int DW = CORDIC_DW;
  localparam logic signed [17:0]     ONE_S = 18'(ONE_Q14);
  localparam logic signed [ANGW-1:0] PI_S  = ANGW'(ANG_PI);
  localparam logic signed [ANGW-1:0] HPI_S = ANGW'(ANG_HALF_PI);

  typedef struct packed {
    tag_t                 tag;
    face_e                face;
    logic                 sat_a;
    logic                 sat_b;
    logic [FSZ_W-1:0]     ra;
    logic [FSZ_W-1:0]     rb;
    logic [DIV_STEPS-1:0] qa;
    logic [DIV_STEPS-1:0] qb;
  } div_t;

  typedef struct packed {
    tag_t        tag;
    logic [17:0] x;
    logic [17:0] y;
    logic [17:0] z;
  } dir_t;

  typedef struct packed {
    tag_t            tag;
    logic [ANGW-1:0] theta;
    logic [DW-1:0]   r;
    logic [17:0]     z;
  } rs_t;

  typedef struct packed {
    tag_t       tag;
    logic [8:0] ui;
    logic [7:0] mu;
    logic [7:0] vi;
    logic [7:0] nu;
  } uv_t;

  typedef struct packed {
    tag_t       tag;
    logic [8:0] c0;
    logic [8:0] c1;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] mu;
    logic [7:0] nu;
  } cr_t;

  typedef struct packed {
    tag_t              tag;
    logic [SRC_AW-1:0] a00;
    logic [SRC_AW-1:0] a01;
    logic [SRC_AW-1:0] a10;
    logic [SRC_AW-1:0] a11;
    logic [16:0]       wa;
    logic [16:0]       wb;
    logic [16:0]       wc;
    logic [16:0]       wd;
  } ad_t;

  typedef struct packed {
    logic        vld;
    logic        proj;
    logic [16:0] wa;
    logic [16:0] wb;
    logic [16:0] wc;
    logic [16:0] wd;
  } fe_t;

  typedef struct packed {
    logic                  vld;
    logic                  proj;
    logic [2:0][3:0][24:0] p;
  } pr_t;

  typedef struct packed {
    logic        vld;
    logic        proj;
    logic [23:0] rgb;
  } sm_t;

  // one restoring division step: remainder doubles, subtract the face size if it fits
  function automatic div_t div_step(div_t s, logic [FSZ_W-1:0] d);
    logic [FSZ_W:0] ta, tb;
    div_t           o;
    o  = s;
    ta = {s.ra, 1'b0};
    tb = {s.rb, 1'b0};
    if (ta >= {1'b0, d}) begin
      o.ra = FSZ_W'(ta - {1'b0, d});
      o.qa = {s.qa[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.ra = ta[FSZ_W-1:0];
      o.qa = {s.qa[DIV_STEPS-2:0], 1'b0};
    end
    if (tb >= {1'b0, d}) begin
      o.rb = FSZ_W'(tb - {1'b0, d});
      o.qb = {s.qb[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.rb = tb[FSZ_W-1:0];
      o.qb = {s.qb[DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  logic en;
  sm_t  sm_q, sm_d;

  // the whole pipeline holds only when a finished pixel cannot enter the result queue
  assign en         = !(sm_q.vld && sm_q.proj && out_full_i);
  assign out_push_o = sm_q.vld && sm_q.proj && !out_full_i;
  assign out_rgb_o  = sm_q.rgb;
  assign q_pop_o    = en && !q_empty_i;

  // ---------------- divider: a = i * 2^15 / face_size ----------------
  div_t div_q [DIV_STEPS+1];
  div_t div_init;

  always_comb begin
    div_init          = '0;
    div_init.tag.vld  = !q_empty_i;
    div_init.tag.proj = q_item_i.proj;
    div_init.tag.addr = q_item_i.addr;
    div_init.tag.rgb  = q_item_i.rgb;
    div_init.face     = q_item_i.face;
    div_init.sat_a    = q_item_i.sat_a;
    div_init.sat_b    = q_item_i.sat_b;
    div_init.ra       = {1'b0, q_item_i.px};
    div_init.rb       = {1'b0, q_item_i.py};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q[0] <= '0;
    end else if (en) begin
      div_q[0] <= div_init;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q[k+1] <= '0;
      end else if (en) begin
        div_q[k+1] <= div_step(div_q[k], cfg_i.fsz);
      end
    end
  end

  // ---------------- direction vector per face ----------------
  dir_t               dir_q, dir_d;
  logic [15:0]        a16, b16;
  logic signed [17:0] as, bs;

  always_comb begin
    a16 = div_q[DIV_STEPS].sat_a ? 16'd32768 : {1'b0, div_q[DIV_STEPS].qa};
    b16 = div_q[DIV_STEPS].sat_b ? 16'd32768 : {1'b0, div_q[DIV_STEPS].qb};
    as  = $signed({2'b00, a16});
    bs  = $signed({2'b00, b16});
    dir_d.tag = div_q[DIV_STEPS].tag;
    unique case (div_q[DIV_STEPS].face)
      FACE_BACK: begin
        dir_d.x = -ONE_S;      dir_d.y = ONE_S - as;  dir_d.z = ONE_S - bs;
      end
      FACE_LEFT: begin
        dir_d.x = as;          dir_d.y = -ONE_S;      dir_d.z = ONE_S - bs;
      end
      FACE_FRONT: begin
        dir_d.x = ONE_S;       dir_d.y = as - ONE_S;  dir_d.z = ONE_S - bs;
      end
      FACE_RIGHT: begin
        dir_d.x = ONE_S - as;  dir_d.y = ONE_S;       dir_d.z = ONE_S - bs;
      end
      FACE_TOP: begin
        dir_d.x = bs - ONE_S;  dir_d.y = as - ONE_S;  dir_d.z = ONE_S;
      end
      FACE_BOTTOM: begin
        dir_d.x = ONE_S - bs;  dir_d.y = as - ONE_S;  dir_d.z = -ONE_S;
      end
      default: begin
        dir_d.x = -ONE_S;      dir_d.y = -ONE_S;      dir_d.z = -ONE_S;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= '0;
    end else if (en) begin
      dir_q <= dir_d;
    end
  end

  // ---------------- longitude cordic ----------------
  localparam int PAY1_W = $bits(tag_t) + 18;
  localparam int PAY2_W = $bits(tag_t) + ANGW;

  logic signed [DW-1:0]   c1_x, c1_y, c1_mag;
  logic signed [ANGW-1:0] c1_ang;
  logic [PAY1_W-1:0]      c1_pay;
  logic                   c1_vld;

  assign c1_x = DW'($signed(dir_q.x)) <<< 8;
  assign c1_y = DW'($signed(dir_q.y)) <<< 8;

  eqc_cordic #(
    .STEPS (CORDIC_STEPS),
    .DW    (DW),
    .AW    (ANGW),
    .PAY_W (PAY1_W)
  ) u_cordic_lon (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dir_q.tag.vld),
    .x_i    (c1_x),
    .y_i    (c1_y),
    .pay_i  ({dir_q.tag, dir_q.z}),
    .vld_o  (c1_vld),
    .ang_o  (c1_ang),
    .mag_o  (c1_mag),
    .pay_o  (c1_pay)
  );

  // ---------------- gain removal: r = mag * 19899 / 2^15 ----------------
  rs_t                  rs_q, rs_d;
  logic signed [DW+15:0] r_prod;

  always_comb begin
    r_prod        = c1_mag * $signed(16'(KINV_Q15));
    rs_d.tag      = c1_pay[PAY1_W-1 -: $bits(tag_t)];
    rs_d.tag.vld  = c1_vld;
    rs_d.z        = c1_pay[17:0];
    rs_d.theta    = c1_ang;
    rs_d.r        = DW'(r_prod >>> 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= '0;
    end else if (en) begin
      rs_q <= rs_d;
    end
  end

  // ---------------- latitude cordic ----------------
  logic signed [DW-1:0]   c2_y, c2_mag;
  logic signed [ANGW-1:0] c2_ang;
  logic [PAY2_W-1:0]      c2_pay;
  logic                   c2_vld;

  assign c2_y = DW'($signed(rs_q.z)) <<< 8;

  eqc_cordic #(
    .STEPS (CORDIC_STEPS),
    .DW    (DW),
    .AW    (ANGW),
    .PAY_W (PAY2_W)
  ) u_cordic_lat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (rs_q.tag.vld),
    .x_i    ($signed(rs_q.r)),
    .y_i    (c2_y),
    .pay_i  ({rs_q.tag, rs_q.theta}),
    .vld_o  (c2_vld),
    .ang_o  (c2_ang),
    .mag_o  (c2_mag),
    .pay_o  (c2_pay)
  );

  // ---------------- source coordinates u, v with 8 fraction bits ----------------
  uv_t                    uv_q, uv_d;
  logic signed [ANGW-1:0] th, thc, ph, phc, tsum, vdif;
  logic [21:0]            tp;
  logic [20:0]            vp;
  logic [30:0]            uprod;
  logic [29:0]            vprod;

  always_comb begin
    th   = $signed(c2_pay[ANGW-1:0]);
    ph   = c2_ang;
    thc  = (th > PI_S) ? PI_S : ((th < -PI_S) ? -PI_S : th);
    phc  = (ph > HPI_S) ? HPI_S : ((ph < -HPI_S) ? -HPI_S : ph);
    tsum = thc + PI_S;
    vdif = HPI_S - phc;
    tp   = tsum[21:0];
    vp   = vdif[20:0];
    uprod = 31'(tp) * 31'(cfg_i.w);
    vprod = 30'(vp) * 30'(cfg_i.w);
    uv_d.tag     = c2_pay[PAY2_W-1 -: $bits(tag_t)];
    uv_d.tag.vld = c2_vld;
    uv_d.ui      = uprod[29:21];
    uv_d.mu      = uprod[20:13];
    uv_d.vi      = vprod[28:21];
    uv_d.nu      = vprod[20:13];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_q <= '0;
    end else if (en) begin
      uv_q <= uv_d;
    end
  end

  // ---------------- columns wrap, rows clamp ----------------
  cr_t        cr_q, cr_d;
  logic [9:0] ui1;
  logic [8:0] vi1;
  logic [7:0] hm1;

  always_comb begin
    // ui never exceeds w, so one compare and subtract is the modulo
    ui1 = {1'b0, uv_q.ui} + 10'd1;
    hm1 = cfg_i.h - 8'd1;
    vi1 = {1'b0, uv_q.vi} + 9'd1;
    cr_d.tag = uv_q.tag;
    cr_d.mu  = uv_q.mu;
    cr_d.nu  = uv_q.nu;
    cr_d.c0  = (uv_q.ui >= cfg_i.w) ? 9'(uv_q.ui - cfg_i.w) : uv_q.ui;
    if (cfg_i.w == 9'd1) begin
      cr_d.c1 = '0;
    end else if (ui1 >= {1'b0, cfg_i.w}) begin
      cr_d.c1 = 9'(ui1 - {1'b0, cfg_i.w});
    end else begin
      cr_d.c1 = ui1[8:0];
    end
    cr_d.r0 = (uv_q.vi > hm1) ? hm1 : uv_q.vi;
    cr_d.r1 = (vi1 > {1'b0, hm1}) ? hm1 : vi1[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q <= '0;
    end else if (en) begin
      cr_q <= cr_d;
    end
  end

  // ---------------- fetch addresses and bilinear weights ----------------
  ad_t         ad_q, ad_d;
  logic [16:0] row0, row1;
  logic [8:0]  imu, inu;

  always_comb begin
    row0 = 17'(cr_q.r0) * 17'(cfg_i.w);
    row1 = 17'(cr_q.r1) * 17'(cfg_i.w);
    imu  = 9'd256 - {1'b0, cr_q.mu};
    inu  = 9'd256 - {1'b0, cr_q.nu};
    ad_d.tag = cr_q.tag;
    // fetch address wraps at the store size
    ad_d.a00 = SRC_AW'(row0 + 17'(cr_q.c0));
    ad_d.a01 = SRC_AW'(row0 + 17'(cr_q.c1));
    ad_d.a10 = SRC_AW'(row1 + 17'(cr_q.c0));
    ad_d.a11 = SRC_AW'(row1 + 17'(cr_q.c1));
    ad_d.wa  = 17'(imu) * 17'(inu);
    ad_d.wb  = 17'(cr_q.mu) * 17'(inu);
    ad_d.wc  = 17'(imu) * 17'(cr_q.nu);
    ad_d.wd  = 17'(cr_q.mu) * 17'(cr_q.nu);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ad_q <= '0;
    end else if (en) begin
      ad_q <= ad_d;
    end
  end

  // ---------------- source store, two copies for four reads ----------------
  // loads write at the same stage where projects read, so store order is kept
  logic              st_we;
  logic [RGB_W-1:0]  pix_a, pix_b, pix_c, pix_d;

  assign st_we = en && ad_q.tag.vld && !ad_q.tag.proj;

  eqc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (SRC_PIXELS)
  ) u_ram_row0 (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (ad_q.tag.addr),
    .wdata_i   (ad_q.tag.rgb),
    .re_i      (en),
    .raddr_a_i (ad_q.a00),
    .raddr_b_i (ad_q.a01),
    .rdata_a_o (pix_a),
    .rdata_b_o (pix_b)
  );

  eqc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (SRC_PIXELS)
  ) u_ram_row1 (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (ad_q.tag.addr),
    .wdata_i   (ad_q.tag.rgb),
    .re_i      (en),
    .raddr_a_i (ad_q.a10),
    .raddr_b_i (ad_q.a11),
    .rdata_a_o (pix_c),
    .rdata_b_o (pix_d)
  );

  fe_t fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q <= '0;
    end else if (en) begin
      fe_q.vld  <= ad_q.tag.vld;
      fe_q.proj <= ad_q.tag.proj;
      fe_q.wa   <= ad_q.wa;
      fe_q.wb   <= ad_q.wb;
      fe_q.wc   <= ad_q.wc;
      fe_q.wd   <= ad_q.wd;
    end
  end

  // ---------------- blend: products, then sum and truncate ----------------
  pr_t pr_q, pr_d;

  always_comb begin
    pr_d.vld  = fe_q.vld;
    pr_d.proj = fe_q.proj;
    for (int ch = 0; ch < 3; ch++) begin
      pr_d.p[ch][0] = 25'(pix_a[8*(2-ch) +: 8]) * 25'(fe_q.wa);
      pr_d.p[ch][1] = 25'(pix_b[8*(2-ch) +: 8]) * 25'(fe_q.wb);
      pr_d.p[ch][2] = 25'(pix_c[8*(2-ch) +: 8]) * 25'(fe_q.wc);
      pr_d.p[ch][3] = 25'(pix_d[8*(2-ch) +: 8]) * 25'(fe_q.wd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_q <= '0;
    end else if (en) begin
      pr_q <= pr_d;
    end
  end

  logic [26:0] csum [3];

  always_comb begin
    sm_d.vld  = pr_q.vld;
    sm_d.proj = pr_q.proj;
    sm_d.rgb  = '0;
    for (int ch = 0; ch < 3; ch++) begin
      csum[ch] = 27'(pr_q.p[ch][0]) + 27'(pr_q.p[ch][1])
               + 27'(pr_q.p[ch][2]) + 27'(pr_q.p[ch][3]);
      sm_d.rgb[8*(2-ch) +: 8] = csum[ch][23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q <= '0;
    end else if (en) begin
      sm_q <= sm_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/equirect_to_cubemap_sampler_top.sv
// top level of the equirect-to-cubemap sampler: config registers, front, queues, back
// depends on eqc_pkg, eqc_fifo, eqc_front, eqc_back (and below it eqc_cordic, eqc_ram)
//
// channel   direction  handshake            payload
// input     in         push / full          req_type_i face_i pixel_x_i pixel_y_i src_addr_i src_rgb_i
// result    out        empty / pop          red_o green_o blue_o
// config    in         cfg_valid_i / ready  cfg_index_i cfg_data_i
//
// one item per cycle sustained while the result queue has room; a project item passes
// through the 15-step divider and the two pipelined cordics on its way to the result queue.
// load items travel the same pipeline and write the store where projects read it.
// the source store is not cleared at reset; entries hold garbage until loaded.
// when the result queue is full the back pipeline holds; the front queue then fills
// and full rises.
`default_nettype none

module equirect_to_cubemap_sampler_top #(
  parameter int CORDIC_STEPS = eqc_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [2:0]  face_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [9:0]  pixel_y_i,
  input  logic [14:0] src_addr_i,
  input  logic [23:0] src_rgb_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [eqc_pkg::REG_W-1:0] cfg_index_i,
  input  logic [eqc_pkg::FSZ_W-1:0] cfg_data_i
);

  import eqc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [FSZ_W-1:0] face_size_q;
  logic [SW_W-1:0]  src_width_q;
  logic [SH_W-1:0]  src_height_q;
  eqc_cfg_t         cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_size_q  <= FACE_SIZE_RST;
      src_width_q  <= SRC_WIDTH_RST;
      src_height_q <= SRC_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_FACE_SIZE:  face_size_q  <= cfg_data_i;
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SW_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i[SH_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one
  assign cfg.fsz = (face_size_q == '0) ? FSZ_W'(1) : face_size_q;
  assign cfg.w   = (src_width_q == '0) ? SW_W'(1) : src_width_q;
  assign cfg.h   = (src_height_q == '0) ? SH_W'(1) : src_height_q;

  // ---------------- front ----------------
  logic      mid_push, mid_full, mid_pop, mid_empty;
  eqc_item_t mid_in, mid_out;

  eqc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push_i     (push),
    .full_o     (full),
    .req_type_i (req_type_i),
    .face_i     (face_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .src_addr_i (src_addr_i),
    .src_rgb_i  (src_rgb_i),
    .q_full_i   (mid_full),
    .q_push_o   (mid_push),
    .q_item_o   (mid_in)
  );

  eqc_fifo #(
    .WIDTH ($bits(eqc_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  // ---------------- back ----------------
  logic              out_push, out_full;
  logic [RGB_W-1:0]  out_rgb, res_rgb;

  eqc_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_empty_i  (mid_empty),
    .q_item_i   (mid_out),
    .q_pop_o    (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_rgb_o  (out_rgb)
  );

  eqc_fifo #(
    .WIDTH (RGB_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_rgb),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_rgb),
    .empty_o (empty)
  );

  assign red_o   = res_rgb[23:16];
  assign green_o = res_rgb[15:8];
  assign blue_o  = res_rgb[7:0];

  // ---------------- assertions ----------------
  a_mid_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> !mid_full)
    else $error("front pushed into a full queue");

  a_mid_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("back popped an empty queue");

  a_out_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result pushed into a full result queue");

endmodule

`default_nettype wire

FILE: tb/sv/tb_equirect_to_cubemap_sampler_top.sv
// testbench for equirect_to_cubemap_sampler_top: a scoreboard class predicts each output pixel
// and checks it against the result queue. Depends on eqc_pkg and the sampler rtl.
module tb_equirect_to_cubemap_sampler_top;
  timeunit 1ns;
  timeprecision 1ps;
  import eqc_pkg::*;

  localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 2 * CORDIC_STEPS_DEF + 60;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 400;
  // every configuration keeps width times height within this many loaded entries
  localparam int FILL_PIXELS = 128;

  class pixel_scoreboard;
    bit [RGB_W-1:0] image [SRC_PIXELS];
    int unsigned fsz, w, h;
    bit [RGB_W-1:0] pixels_due [$];
    int mismatches;

    function new();
      fsz = FACE_SIZE_RST;
      w = SRC_WIDTH_RST;
      h = SRC_HEIGHT_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [REG_W-1:0] idx, logic [FSZ_W-1:0] data);
      case (idx)
        REG_FACE_SIZE: fsz = data;
        REG_SRC_WIDTH: w = data[SW_W-1:0];
        REG_SRC_HEIGHT: h = data[SH_W-1:0];
        default: ;
      endcase
    endfunction

    // vectoring rotation: angle in pi/2^20 units, magnitude still carries the gain
    function longint vector_angle(longint x, longint y, output longint mag);
      longint ang, dx, dy;
      int k;
      ang = 0;
      if (x == 0 && y == 0) begin
        mag = 0;
        return 0;
      end
      if (x < 0) begin
        ang = (y >= 0) ? ANG_PI : -ANG_PI;
        x = -x;
        y = -y;
      end
      for (k = 0; k < CORDIC_STEPS_DEF; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y >= 0) begin
          x += dx; y -= dy; ang += longint'(ATAN_TAB[k]);
        end else begin
          x -= dx; y += dy; ang -= longint'(ATAN_TAB[k]);
        end
      end
      mag = x;
      return ang;
    endfunction

    function bit [7:0] mix(bit [RGB_W-1:0] pa, bit [RGB_W-1:0] pb, bit [RGB_W-1:0] pc,
                           bit [RGB_W-1:0] pd, int sh, longint mu, longint nu);
      longint s;
      s = longint'((pa >> sh) & 255) * (256 - mu) * (256 - nu)
        + longint'((pb >> sh) & 255) * mu * (256 - nu)
        + longint'((pc >> sh) & 255) * (256 - mu) * nu
        + longint'((pd >> sh) & 255) * mu * nu;
      return s[23:16];
    endfunction

    function void note_item(bit req, bit [2:0] face, bit [9:0] px, bit [9:0] py,
                            bit [SRC_AW-1:0] addr, bit [RGB_W-1:0] rgb);
      longint ef, ew, eh, a, b, x, y, z, mag, rad, spare, theta, phi;
      longint uf, vf, ui, vi, mu, nu, c0, c1, r0, r1;
      bit [RGB_W-1:0] pa, pb, pc, pd;
      if (!req) begin
        image[addr] = rgb;
        return;
      end
      ef = fsz ? fsz : 1;
      ew = w ? w : 1;
      eh = h ? h : 1;
      a = (longint'(px) * 32768) / ef;
      b = (longint'(py) * 32768) / ef;
      if (a > 32768) a = 32768;
      if (b > 32768) b = 32768;
      case (face_e'(face))
        FACE_BACK:   begin x = -ONE_Q14;     y = ONE_Q14 - a;  z = ONE_Q14 - b; end
        FACE_LEFT:   begin x = a;            y = -ONE_Q14;     z = ONE_Q14 - b; end
        FACE_FRONT:  begin x = ONE_Q14;      y = a - ONE_Q14;  z = ONE_Q14 - b; end
        FACE_RIGHT:  begin x = ONE_Q14 - a;  y = ONE_Q14;      z = ONE_Q14 - b; end
        FACE_TOP:    begin x = b - ONE_Q14;  y = a - ONE_Q14;  z = ONE_Q14;     end
        FACE_BOTTOM: begin x = ONE_Q14 - b;  y = a - ONE_Q14;  z = -ONE_Q14;    end
        default:     begin x = -ONE_Q14;     y = -ONE_Q14;     z = -ONE_Q14;    end
      endcase
      theta = vector_angle(x * 256, y * 256, mag);
      rad = (mag * KINV_Q15) >>> 15;
      phi = vector_angle(rad, z * 256, spare);
      if (theta > ANG_PI) theta = ANG_PI;
      if (theta < -ANG_PI) theta = -ANG_PI;
      if (phi > ANG_HALF_PI) phi = ANG_HALF_PI;
      if (phi < -ANG_HALF_PI) phi = -ANG_HALF_PI;
      uf = ((theta + ANG_PI) * ew) >> 13;
      vf = ((ANG_HALF_PI - phi) * ew) >> 13;
      ui = uf >> 8; mu = uf & 255;
      vi = vf >> 8; nu = vf & 255;
      c0 = ui % ew;
      c1 = (ui + 1) % ew;
      r0 = (vi > eh - 1) ? eh - 1 : vi;
      r1 = (vi + 1 > eh - 1) ? eh - 1 : vi + 1;
      pa = image[(r0 * ew + c0) % SRC_PIXELS];
      pb = image[(r0 * ew + c1) % SRC_PIXELS];
      pc = image[(r1 * ew + c0) % SRC_PIXELS];
      pd = image[(r1 * ew + c1) % SRC_PIXELS];
      pixels_due.push_back({mix(pa, pb, pc, pd, 16, mu, nu), mix(pa, pb, pc, pd, 8, mu, nu),
                            mix(pa, pb, pc, pd, 0, mu, nu)});
    endfunction

    function void check_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] bl);
      bit [RGB_W-1:0] want;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h%h%h", r, g, bl);
        return;
      end
      want = pixels_due.pop_front();
      if (want != {r, g, bl}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                   want[23:16], want[15:8], want[7:0], r, g, bl);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic req_type_i = 1'b0;
  logic [2:0] face_i = '0;
  logic [9:0] pixel_x_i = '0;
  logic [9:0] pixel_y_i = '0;
  logic [14:0] src_addr_i = '0;
  logic [23:0] src_rgb_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [REG_W-1:0] cfg_index_i = '0;
  logic [FSZ_W-1:0] cfg_data_i = '0;
  logic full, empty, cfg_ready_o;
  logic [7:0] red_o, green_o, blue_o;

  pixel_scoreboard sb = new();
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  equirect_to_cubemap_sampler_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .req_type_i(req_type_i), .face_i(face_i), .pixel_x_i(pixel_x_i),
    .pixel_y_i(pixel_y_i), .src_addr_i(src_addr_i), .src_rgb_i(src_rgb_i),
    .empty(empty), .pop(pop),
    .red_o(red_o), .green_o(green_o), .blue_o(blue_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full)
        sb.note_item(req_type_i, face_i, pixel_x_i, pixel_y_i, src_addr_i, src_rgb_i);
      if (pop && !empty) sb.check_pixel(red_o, green_o, blue_o);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_item(bit req, bit [2:0] face, bit [9:0] px, bit [9:0] py,
                           bit [14:0] addr, bit [23:0] rgb);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= req;
    face_i <= face;
    pixel_x_i <= px;
    pixel_y_i <= py;
    src_addr_i <= addr;
    src_rgb_i <= rgb;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_project(bit [2:0] face, bit [9:0] px, bit [9:0] py);
    send_item(1'b1, face, px, py, 15'($urandom), 24'($urandom));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_W-1:0] idx, logic [FSZ_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic random_item();
    int unsigned lim;
    lim = (sb.fsz == 0) ? 0 : ((sb.fsz > 1024) ? 1023 : sb.fsz - 1);
    if ($urandom_range(0, 3) == 0)
      send_item(1'b0, 3'($urandom), 10'($urandom), 10'($urandom),
                15'($urandom_range(0, FILL_PIXELS - 1)), 24'($urandom));
    else if ($urandom_range(0, 1) == 0)
      send_project(3'($urandom_range(0, 7)), 10'($urandom_range(0, lim)),
                   10'($urandom_range(0, lim)));
    else
      send_project(3'($urandom), 10'($urandom), 10'($urandom));
  endtask

  initial begin
    int p, k, f, n;
    logic [FSZ_W-1:0] fs [6];
    logic [FSZ_W-1:0] ws [6];
    logic [FSZ_W-1:0] hs [6];

    // width and height stay within the loaded area, upper bits get masked off
    fs = '{11'd256, 11'd1, 11'd1024, 11'd0, 11'd37, 11'd2047};
    ws = '{11'd16, 11'd2, 11'd32, 11'd0, 11'd77, 11'h47F};
    hs = '{11'd8, 11'd1, 11'd4, 11'd0, 11'd1, 11'h301};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_SRC_WIDTH, 11'd16);
    write_reg(REG_SRC_HEIGHT, 11'd8);

    // load the area that every fetch below can reach
    for (k = 0; k < FILL_PIXELS; k++)
      send_item(1'b0, 3'd0, 10'd0, 10'd0, 15'(k),
                (k == 0) ? 24'h000000 : (k == 1) ? 24'hFFFFFF : 24'($urandom));

    // directed: every face, corners, centers and beyond-face pixels
    for (f = 0; f < 8; f++) begin
      send_project(3'(f), 10'd0, 10'd0);
      send_project(3'(f), 10'd128, 10'd128);
    end
    send_project(3'(FACE_FRONT), 10'd255, 10'd255);
    send_project(3'(FACE_TOP), 10'd1023, 10'd1023);
    send_project(3'(FACE_BOTTOM), 10'd1023, 10'd0);
    send_project(3'(FACE_LEFT), 10'd0, 10'd1023);
    send_item(1'b0, 3'd0, 10'd0, 10'd0, 15'h7FFF, 24'hFFFFFF);
    wait_idle();
    write_reg(REG_UNUSED, 11'h7FF);

    for (p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(REG_FACE_SIZE, fs[p]);
      write_reg(REG_SRC_WIDTH, ws[p]);
      write_reg(REG_SRC_HEIGHT, hs[p]);
      tx_idle = (p < 5);
      rx_idle = (p < 5);
      if (p == 2) hold_req = 1'b1;
      // the long hold needs enough items to fill the block
      n = (p == 2) ? 150 : 50;
      for (k = 0; k < n; k++) random_item();
      // pause the sender until the block has drained
      if (p == 1) begin
        push <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge clk_i);
      end
    end

    push <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/eqc_pkg.sv
rtl/core/eqc_fifo.sv
rtl/core/eqc_ram.sv
rtl/core/eqc_cordic.sv
rtl/core/eqc_front.sv
rtl/core/eqc_back.sv
rtl/core/equirect_to_cubemap_sampler_top.sv
tb/sv/tb_equirect_to_cubemap_sampler_top.sv
